// File: rtl/dpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpr_pkg: shared types and constants of the datagram port registry
// Field widths, command codes, table entry layout and controller states.
// ----------------------------------------------------------------------------
package dpr_pkg;

  localparam int unsigned PORT_W = 16;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SVC_W  = 4;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned CMD_W  = 2;

  // port_num, peer_addr, peer_port, service_code, assoc_key -> 100 bits
  localparam int unsigned IN_DATA_W  = 104;
  // port_out, accepted, service_out, assoc_out, dest_addr, dest_port -> 101 bits
  localparam int unsigned OUT_DATA_W = 104;

  localparam int unsigned PORT_COUNT_DEF = 65536;
  localparam int unsigned FIRST_DYN_DEF  = 1024;

  // Quotient of a 16-bit port by a table size of at least 2048 stays below 32
  localparam int unsigned QUOT_W  = 5;
  // ceil(2^32 / table size) for table sizes of at least 2048
  localparam int unsigned RECIP_W = 22;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER = 2'd0,
    CMD_SEND     = 2'd1,
    CMD_RECEIVE  = 2'd2
  } cmd_e;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_ADDR  = 5'b01000,
    ST_LOOK  = 5'b10000
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] flt_addr;
    logic [PORT_W-1:0] flt_port;
    logic [SVC_W-1:0]  svc;
    logic [KEY_W-1:0]  key;
  } entry_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] peer_addr;
    logic [PORT_W-1:0] peer_port;
    logic [SVC_W-1:0]  svc;
    logic [KEY_W-1:0]  key;
  } item_t;

  typedef struct packed {
    logic [PORT_W-1:0] dest_port;
    logic [ADDR_W-1:0] dest_addr;
    logic [KEY_W-1:0]  assoc;
    logic [SVC_W-1:0]  svc;
    logic              acc;
    logic [PORT_W-1:0] port;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/datagram_port_registry.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// datagram_port_registry: local port table with register/send/receive requests
// Port-indexed memory of service, key and remote filter; auto port assignment.
// ----------------------------------------------------------------------------
//  channel  | direction | tuser | tdata
//  s_axis   | in        | cmd   | port_num, peer_addr, peer_port, service_code,
//           |           |       | assoc_key
//  m_axis   | out       | -     | port_out, accepted, service_out, assoc_out,
//           |           |       | dest_addr, dest_port
//
//  A request passes accept, quotient of the port by PORT_COUNT, table read
//  (register writes here) and result into the output register, in that order.
//  The quotient and the table read are each registered before the result.
//  After reset a clearing pass zeroes the table, one entry per cycle,
//  with s_axis_tready low until the last entry is cleared.
//  A result waiting in the output register holds the next request in the
//  lookup stage, and s_axis_tready stays low until that request moves on.
// ----------------------------------------------------------------------------
module datagram_port_registry #(
  parameter int unsigned PORT_COUNT         = dpr_pkg::PORT_COUNT_DEF,
  parameter int unsigned FIRST_DYNAMIC_PORT = dpr_pkg::FIRST_DYN_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] port_num, [47:16] peer_addr, [63:48] peer_port,
  // [67:64] service_code, [99:68] assoc_key
  input  wire logic [dpr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] cmd
  input  wire logic [dpr_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [15:0] port_out, [16] accepted, [20:17] service_out, [52:21] assoc_out,
  // [84:53] dest_addr, [100:85] dest_port
  output logic [dpr_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
  import dpr_pkg::*;

  localparam int unsigned IDX_W = $clog2(PORT_COUNT);
  localparam longint unsigned RECIP_L =
    ((64'd1 << 32) + 64'(PORT_COUNT) - 64'd1) / 64'(PORT_COUNT);
  localparam logic [RECIP_W-1:0]  RECIP      = RECIP_W'(RECIP_L);
  localparam logic [PORT_W:0]     COUNT_EXT  = (PORT_W+1)'(PORT_COUNT);
  localparam logic [PORT_W-1:0]   FIRST_PORT = PORT_W'(FIRST_DYNAMIC_PORT);
  localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(PORT_COUNT - 1);
  localparam int unsigned         PROD_W     = PORT_W + RECIP_W;

  state_e                 state_q, state_d;
  logic [IDX_W-1:0]       clr_q, clr_d;
  logic [PORT_W-1:0]      nxt_q, nxt_d;
  item_t                  item_q, item_d;
  logic [QUOT_W-1:0]      quot_q, quot_d;
  result_t                res_q, res_d;
  logic                   m_valid_q, m_valid_d;

  entry_t                 table_mem [PORT_COUNT];
  entry_t                 rd_q;
  logic                   mem_we;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_addr;
  entry_t                 mem_wdata;

  item_t                  in_item;
  logic                   in_fire;
  logic [PORT_W:0]        nxt_inc;
  logic [PROD_W-1:0]      quot_prod;
  logic [PORT_W:0]        rem;
  logic [IDX_W-1:0]       slot;
  logic                   out_free;
  logic                   addr_ok;
  logic                   port_ok;

  assign in_item.cmd       = s_axis_tuser;
  assign in_item.port      = s_axis_tdata[15:0];
  assign in_item.peer_addr = s_axis_tdata[47:16];
  assign in_item.peer_port = s_axis_tdata[63:48];
  assign in_item.svc       = s_axis_tdata[67:64];
  assign in_item.key       = s_axis_tdata[99:68];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), res_q};

  assign nxt_inc   = {1'b0, nxt_q} + (PORT_W+1)'(1);
  // reciprocal multiply gives the exact quotient for all 16-bit ports
  assign quot_prod = PROD_W'(item_q.port) * PROD_W'(RECIP);
  assign rem       = {1'b0, item_q.port} - (PORT_W+1)'((PORT_W+1)'(quot_q) * COUNT_EXT);
  assign slot      = rem[IDX_W-1:0];

  assign addr_ok = (rd_q.flt_addr == '0) || (rd_q.flt_addr == item_q.peer_addr);
  assign port_ok = (rd_q.flt_port == '0) || (rd_q.flt_port == item_q.peer_port);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    nxt_d     = nxt_q;
    item_d    = item_q;
    quot_d    = quot_q;
    res_d     = res_q;
    m_valid_d = m_valid_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = slot;
    mem_wdata = '{flt_addr: item_q.peer_addr, flt_port: item_q.peer_port,
                  svc: item_q.svc, key: item_q.key};

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          item_d = in_item;
          // zero port on register takes the next dynamic number
          if (in_item.cmd == CMD_REGISTER && in_item.port == '0) begin
            item_d.port = nxt_q;
            nxt_d = (nxt_inc >= COUNT_EXT) ? FIRST_PORT : nxt_inc[PORT_W-1:0];
          end
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        quot_d  = quot_prod[32 +: QUOT_W];
        state_d = ST_ADDR;
      end
      ST_ADDR: begin
        mem_re  = 1'b1;
        mem_we  = (item_q.cmd == CMD_REGISTER);
        state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (out_free) begin
          res_d      = '0;
          res_d.port = item_q.port;
          unique case (item_q.cmd)
            CMD_REGISTER: begin
              res_d.svc   = item_q.svc;
              res_d.assoc = item_q.key;
            end
            CMD_SEND: begin
              res_d.svc       = rd_q.svc;
              res_d.assoc     = rd_q.key;
              res_d.dest_addr = (item_q.peer_addr != '0) ? item_q.peer_addr : rd_q.flt_addr;
              res_d.dest_port = (item_q.peer_port != '0) ? item_q.peer_port : rd_q.flt_port;
            end
            CMD_RECEIVE: begin
              res_d.svc   = rd_q.svc;
              res_d.assoc = rd_q.key;
              res_d.acc   = addr_ok && port_ok;
            end
            default: begin
              res_d.svc = '0;
            end
          endcase
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      nxt_q     <= FIRST_PORT;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      nxt_q     <= nxt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    quot_q <= quot_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= table_mem[mem_addr];
    end
  end

  // no request enters while the table is being cleared
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("request accepted during clearing pass");

  // clearing pass ends only after the last entry
  a_clear_complete : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && $past(state_q) == ST_CLEAR) |-> ($past(clr_q) == LAST_IDX))
    else $error("clearing pass left entries untouched");

  // table index stays inside the memory
  a_slot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADDR) |-> (rem < COUNT_EXT))
    else $error("table slot out of range");

  // a blocked result holds the next request in the lookup stage
  a_hold_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOK && m_valid_q && !m_axis_tready) |=> (state_q == ST_LOOK))
    else $error("result overwritten while output stalled");

  // dynamic counter never drops below its first value
  a_counter_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nxt_q >= FIRST_PORT))
    else $error("dynamic port counter below first dynamic port");

endmodule
`default_nettype wire

// File: bench/datagram_port_registry_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datagram_port_registry_checker: scoreboard for the port registry
// Watches the request and result streams and keeps its own port table and
// dynamic port counter. Each accepted request yields one predicted lookup.
// Each result is compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module datagram_port_registry_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [dpr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [dpr_pkg::CMD_W-1:0]      s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [dpr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output int                             mismatch_count_o,
  output int                             pending_count_o,
  output int                             results_checked_o,
  output int                             receives_passed_o
);
  import dpr_pkg::*;

  typedef struct {
    bit [ADDR_W-1:0] addr;
    bit [PORT_W-1:0] port;
    bit [SVC_W-1:0]  svc;
    bit [KEY_W-1:0]  key;
  } binding_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic              acc;
    logic [SVC_W-1:0]  svc;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] dest_addr;
    logic [PORT_W-1:0] dest_port;
  } lookup_t;

  binding_t        port_bindings [PORT_COUNT_DEF];
  bit [PORT_W-1:0] next_dynamic_port = PORT_W'(FIRST_DYN_DEF);
  lookup_t         expected_lookups [$];

  // Apply one request to the table copy and return the lookup it must produce
  function automatic lookup_t resolve_request(input bit [CMD_W-1:0]  code,
                                              input bit [PORT_W-1:0] port,
                                              input bit [ADDR_W-1:0] peer_addr,
                                              input bit [PORT_W-1:0] peer_port,
                                              input bit [SVC_W-1:0]  svc,
                                              input bit [KEY_W-1:0]  key);
    lookup_t     r;
    binding_t    entry;
    int unsigned slot;
    r = '0;
    r.port = port;
    case (code)
      CMD_REGISTER: begin
        if (port == '0) begin
          r.port = next_dynamic_port;
          if (32'(next_dynamic_port) + 32'd1 >= PORT_COUNT_DEF) begin
            next_dynamic_port = PORT_W'(FIRST_DYN_DEF);
          end else begin
            next_dynamic_port = next_dynamic_port + 1'b1;
          end
        end
        slot = 32'(r.port) % PORT_COUNT_DEF;
        port_bindings[slot] = '{addr: peer_addr, port: peer_port, svc: svc, key: key};
        r.svc = svc;
        r.key = key;
      end
      CMD_SEND: begin
        entry = port_bindings[32'(port) % PORT_COUNT_DEF];
        r.svc = entry.svc;
        r.key = entry.key;
        r.dest_addr = (peer_addr != '0) ? peer_addr : entry.addr;
        r.dest_port = (peer_port != '0) ? peer_port : entry.port;
      end
      CMD_RECEIVE: begin
        entry = port_bindings[32'(port) % PORT_COUNT_DEF];
        r.acc = (entry.addr == '0 || entry.addr == peer_addr) &&
                (entry.port == '0 || entry.port == peer_port);
        r.svc = entry.svc;
        r.key = entry.key;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin : watch_channels
    lookup_t got;
    lookup_t want;
    if (rst_ni) begin
      // check the result first so a request taken at this edge cannot match it
      if (m_axis_tvalid && m_axis_tready) begin
        got.port      = m_axis_tdata[15:0];
        got.acc       = m_axis_tdata[16];
        got.svc       = m_axis_tdata[20:17];
        got.key       = m_axis_tdata[52:21];
        got.dest_addr = m_axis_tdata[84:53];
        got.dest_port = m_axis_tdata[100:85];
        results_checked_o++;
        if (expected_lookups.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) begin
            $display("%0t: result with no request pending: port %h acc %b svc %h key %h",
                     $time, got.port, got.acc, got.svc, got.key);
          end
        end else begin
          want = expected_lookups.pop_front();
          if (got.port !== want.port || got.acc !== want.acc || got.svc !== want.svc ||
              got.key !== want.key || got.dest_addr !== want.dest_addr ||
              got.dest_port !== want.dest_port) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%0t: lookup mismatch (expected/actual) port %h/%h acc %b/%b svc %h/%h",
                       $time, want.port, got.port, want.acc, got.acc, want.svc, got.svc);
              $display("  key %h/%h dest_addr %h/%h dest_port %h/%h",
                       want.key, got.key, want.dest_addr, got.dest_addr,
                       want.dest_port, got.dest_port);
            end
          end else if (want.acc) begin
            receives_passed_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_lookups.push_back(resolve_request(s_axis_tuser, s_axis_tdata[15:0],
                                                   s_axis_tdata[47:16], s_axis_tdata[63:48],
                                                   s_axis_tdata[67:64], s_axis_tdata[99:68]));
      end
    end
    pending_count_o = expected_lookups.size();
  end

endmodule

// File: bench/datagram_port_registry_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datagram_port_registry_tb: stimulus and verdict for the port registry
// Directed register/send/receive/reserved requests on the table edges, a run of
// automatic registrations from the dynamic counter, then random requests
// under four idle and backpressure mixes, checked by the scoreboard.
// ----------------------------------------------------------------------------
module datagram_port_registry_tb;
  import dpr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  // automatic registrations in a row from the dynamic counter
  localparam int unsigned SWEEP_ITEMS  = 16;
  localparam int unsigned PHASE_ITEMS  = 175;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tready = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int gap_pct   = 0;
  int stall_pct = 0;
  int requests_issued;
  int mismatch_count;
  int pending_count;
  int results_checked;
  int receives_passed;

  // last filter written to each explicit port, used to aim receives at it
  bit [ADDR_W-1:0] hint_addr [PORT_COUNT_DEF];
  bit [PORT_W-1:0] hint_port [PORT_COUNT_DEF];
  bit [PORT_W-1:0] port_pool [12] = '{16'd0, 16'd1, 16'd2, 16'd53, 16'd80, 16'd443,
                                      16'd1023, 16'd1024, 16'd1025, 16'd32768,
                                      16'd65534, 16'd65535};

  datagram_port_registry i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  datagram_port_registry_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .mismatch_count_o  (mismatch_count),
    .pending_count_o   (pending_count),
    .results_checked_o (results_checked),
    .receives_passed_o (receives_passed)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end

  // Hold one request on the bus until the block takes it
  task automatic issue_request(input logic [CMD_W-1:0]  code,
                               input bit   [PORT_W-1:0] port,
                               input bit   [ADDR_W-1:0] peer_addr,
                               input bit   [PORT_W-1:0] peer_port,
                               input bit   [SVC_W-1:0]  svc,
                               input bit   [KEY_W-1:0]  key);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= code;
    s_axis_tdata  <= {4'b0, key, svc, peer_port, peer_addr, port};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    requests_issued++;
    if (code == CMD_REGISTER && port != '0) begin
      hint_addr[port] = peer_addr;
      hint_port[port] = peer_port;
    end
  endtask

  initial begin : stimulus
    logic [CMD_W-1:0]  code;
    bit   [PORT_W-1:0] port;
    bit   [ADDR_W-1:0] paddr;
    bit   [PORT_W-1:0] pport;
    bit   [SVC_W-1:0]  svc;
    bit   [KEY_W-1:0]  key;
    int unsigned       pick;
    int                phase_gap [4];
    int                phase_stall [4];
    phase_gap   = '{0, 46, 0, 32};
    phase_stall = '{0, 0, 46, 32};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fresh table: any sender passes, send resolves to zero
    issue_request(CMD_RECEIVE, 16'd0, 32'h1234_5678, 16'h0050, 4'h0, 32'h0);
    issue_request(CMD_SEND, 16'hFFFF, 32'h0, 16'h0, 4'h0, 32'h0);
    issue_request(CMD_REGISTER, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
    // given fields win over the stored filter when nonzero
    issue_request(CMD_SEND, 16'hFFFF, 32'h0, 16'h0, 4'h0, 32'h0);
    issue_request(CMD_SEND, 16'hFFFF, 32'h0A00_0001, 16'h0001, 4'h0, 32'h0);
    issue_request(CMD_SEND, 16'hFFFF, 32'h0A00_0001, 16'h0, 4'h0, 32'h0);
    issue_request(CMD_SEND, 16'hFFFF, 32'h0, 16'h1F90, 4'h0, 32'h0);
    issue_request(CMD_RECEIVE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'h0, 32'h0);
    issue_request(CMD_RECEIVE, 16'hFFFF, 32'hFFFF_FFFE, 16'hFFFF, 4'h0, 32'h0);
    issue_request(CMD_RECEIVE, 16'hFFFF, 32'hFFFF_FFFF, 16'h0, 4'h0, 32'h0);
    // automatic assignment with an open filter, then an address-only filter
    issue_request(CMD_REGISTER, 16'd0, 32'h0, 16'h0, 4'h3, 32'hDEAD_BEEF);
    issue_request(CMD_RECEIVE, 16'd1024, 32'hC0A8_0101, 16'd5353, 4'h0, 32'h0);
    issue_request(CMD_REGISTER, 16'd0, 32'hC0A8_0001, 16'h0, 4'h7, 32'h0000_0001);
    issue_request(CMD_RECEIVE, 16'd1025, 32'hC0A8_0001, 16'hBEEF, 4'h0, 32'h0);
    issue_request(CMD_RECEIVE, 16'd1025, 32'hC0A8_0002, 16'hBEEF, 4'h0, 32'h0);
    // port-only filter
    issue_request(CMD_REGISTER, 16'd1, 32'h0, 16'd53, 4'h0, 32'h0);
    issue_request(CMD_RECEIVE, 16'd1, 32'h0808_0808, 16'd53, 4'h0, 32'h0);
    issue_request(CMD_RECEIVE, 16'd1, 32'h0808_0808, 16'd54, 4'h0, 32'h0);
    // reserved command leaves the table alone
    issue_request(CMD_RESERVED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
    issue_request(CMD_RESERVED, 16'd0, 32'h0, 16'h0, 4'h0, 32'h0);
    issue_request(CMD_SEND, 16'hFFFF, 32'h0, 16'h0, 4'h0, 32'h0);
    // overwrite an entry
    issue_request(CMD_REGISTER, 16'd1, 32'h8000_0000, 16'h8000, 4'h8, 32'h8000_0000);
    issue_request(CMD_SEND, 16'd1, 32'h0, 16'h0, 4'h0, 32'h0);
    issue_request(CMD_RECEIVE, 16'd0, 32'h0, 16'h0, 4'h0, 32'h0);

    // advance the dynamic counter with back to back automatic registrations
    for (int i = 0; i < SWEEP_ITEMS; i++) begin
      issue_request(CMD_REGISTER, 16'd0,
                    ($urandom_range(2) == 0) ? 32'h0 : 32'($urandom),
                    ($urandom_range(2) == 0) ? 16'h0 : 16'($urandom),
                    4'($urandom), 32'($urandom));
    end

    for (int ph = 0; ph < 4; ph++) begin
      // drop valid and let every pending result come back before the next mix
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while (pending_count != 0) @(posedge clk_i);
      gap_pct   = phase_gap[ph];
      stall_pct <= phase_stall[ph];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick  = $urandom_range(99);
        port  = ($urandom_range(3) != 0) ? port_pool[$urandom_range(11)] : 16'($urandom);
        paddr = 32'($urandom);
        pport = 16'($urandom);
        svc   = 4'($urandom);
        key   = 32'($urandom);
        if (pick < 25) begin
          code = CMD_REGISTER;
          if ($urandom_range(4) == 0) port = '0;
          if ($urandom_range(2) == 0) paddr = '0;
          if ($urandom_range(2) == 0) pport = '0;
        end else if (pick < 55) begin
          code = CMD_SEND;
          if ($urandom_range(1) == 0) paddr = '0;
          if ($urandom_range(1) == 0) pport = '0;
        end else if (pick < 95) begin
          code = CMD_RECEIVE;
          // aim most receives at the stored filter, some with one field off
          case ($urandom_range(3))
            0: ;
            1: begin
              paddr = hint_addr[port];
              pport = hint_port[port];
            end
            2: paddr = hint_addr[port];
            default: pport = hint_port[port];
          endcase
        end else begin
          code = CMD_RESERVED;
        end
        issue_request(code, port, paddr, pport, svc, key);
      end
    end

    s_axis_tvalid <= 1'b0;
    stall_pct <= 0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests, %0d of them automatic registrations in a row;",
             requests_issued, SWEEP_ITEMS);
    $display("%0d results checked, %0d receives passed the filter, %0d still outstanding",
             results_checked, receives_passed, pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dpr_pkg.sv
rtl/datagram_port_registry.sv
bench/datagram_port_registry_checker.sv
bench/datagram_port_registry_tb.sv
